FILE: sv/mbps_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbps_pkg - shared types and constants for the masked byte pattern search
// Status codes, register indexes, the result record and queue sizing.
// ----------------------------------------------------------------------------
package mbps_pkg;

   // field widths fixed by the interface
   localparam int BYTE_W       = 8;
   localparam int OFFSET_W     = 32;
   localparam int LENGTH_W     = 6;
   localparam int CARE_W       = 32;
   localparam int CSR_DATA_W   = 64;
   localparam int CSR_INDEX_W  = 3;
   localparam int PAT_BYTES    = 32;
   localparam int PAT_SEL_W    = 5;

   // result queue sizing
   localparam int QUEUE_DEPTH  = 2;
   localparam int QUEUE_PTR_W  = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W  = $clog2(QUEUE_DEPTH + 1);

   // configuration register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_PATTERN_0      = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_PATTERN_1      = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_PATTERN_2      = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_PATTERN_3      = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_CARE_MASK      = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_PATTERN_LENGTH = 3'd5;

   // configuration reset values
   localparam logic [CARE_W-1:0]   CARE_MASK_RESET      = '1;
   localparam logic [LENGTH_W-1:0] PATTERN_LENGTH_RESET = 6'd1;

   // saturation value of the byte count
   localparam logic [OFFSET_W-1:0] COUNT_MAX = '1;

   typedef enum logic [1:0] {
      STATUS_FOUND     = 2'd0,
      STATUS_NOT_FOUND = 2'd1,
      STATUS_INVALID   = 2'd2
   } search_status_type;

   typedef struct packed {
      search_status_type    status;
      logic [OFFSET_W-1:0]  offset;
   } result_type;

   typedef struct packed {
      logic        valid;
      result_type  result;
   } result_push_type;

endpackage

FILE: sv/mbps_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbps_front - byte intake and match classification
// Holds the pattern registers, the byte window and the byte count, compares
// the newest bytes with the masked pattern and emits at most one result per
// accepted byte.
// ----------------------------------------------------------------------------
module mbps_front #(
   parameter int PATTERN_MAX = 32
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [mbps_pkg::BYTE_W-1:0]          req_data_byte,
   input  logic                                 req_last_byte,
   input  logic                                 csr_write_enable,
   input  logic [mbps_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [mbps_pkg::CSR_DATA_W-1:0]      csr_write_data,
   input  logic                                 queue_full,
   output mbps_pkg::result_push_type            push
);

   localparam int PAT_PER_REG = mbps_pkg::CSR_DATA_W / mbps_pkg::BYTE_W;
   localparam int PAT_LO_W    = $clog2(PAT_PER_REG);

   logic [mbps_pkg::PAT_BYTES-1:0][mbps_pkg::BYTE_W-1:0] pattern_ff;
   logic [mbps_pkg::CARE_W-1:0]                          care_ff;
   logic [mbps_pkg::LENGTH_W-1:0]                        length_ff;

   logic [PATTERN_MAX-1:0][mbps_pkg::BYTE_W-1:0] window_ff;
   logic [PATTERN_MAX-1:0][mbps_pkg::BYTE_W-1:0] window_in;
   logic [mbps_pkg::OFFSET_W-1:0]                seen_ff;
   logic [mbps_pkg::OFFSET_W-1:0]                seen_in;
   logic                                         reported_ff;

   logic                            accept;
   logic                            length_ok;
   logic [PATTERN_MAX-1:0]          mismatch;
   logic                            found;
   logic [mbps_pkg::OFFSET_W-1:0]   length_wide;

   assign req_stall   = queue_full;
   assign accept      = req_valid && !req_stall;
   assign length_wide = mbps_pkg::OFFSET_W'(length_ff);
   assign length_ok   = (length_ff != '0) && (32'(length_ff) <= 32'(PATTERN_MAX));

   // shift the new byte into the window
   always_comb begin
      window_in[0] = req_data_byte;
      for (int k = 1; k < PATTERN_MAX; k++) begin
         window_in[k] = window_ff[k-1];
      end
   end

   // advance the byte count, holding at saturation
   assign seen_in = (seen_ff == mbps_pkg::COUNT_MAX) ? seen_ff : seen_ff + 1'b1;

   // masked compare: window slot k lines up with pattern byte length-1-k
   always_comb begin
      logic [mbps_pkg::LENGTH_W-1:0]  pat_pos;
      logic [mbps_pkg::PAT_SEL_W-1:0] pat_sel;
      for (int k = 0; k < PATTERN_MAX; k++) begin
         pat_pos     = length_ff - mbps_pkg::LENGTH_W'(k) - 1'b1;
         pat_sel     = pat_pos[mbps_pkg::PAT_SEL_W-1:0];
         mismatch[k] = (32'(k) < 32'(length_ff)) && care_ff[pat_sel]
                       && (window_in[k] != pattern_ff[pat_sel]);
      end
   end

   assign found = length_ok && !reported_ff && (seen_in >= length_wide) && (mismatch == '0);

   // classify the transfer into a result or nothing
   always_comb begin
      push.valid         = accept && (found || (req_last_byte && (!length_ok || !reported_ff)));
      push.result.offset = '0;
      priority if (found) begin
         push.result.status = mbps_pkg::STATUS_FOUND;
         push.result.offset = seen_in - length_wide;
      end else if (!length_ok) begin
         push.result.status = mbps_pkg::STATUS_INVALID;
      end else begin
         push.result.status = mbps_pkg::STATUS_NOT_FOUND;
      end
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_ff <= '0;
         care_ff    <= mbps_pkg::CARE_MASK_RESET;
         length_ff  <= mbps_pkg::PATTERN_LENGTH_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            mbps_pkg::CSR_PATTERN_0, mbps_pkg::CSR_PATTERN_1,
            mbps_pkg::CSR_PATTERN_2, mbps_pkg::CSR_PATTERN_3: begin
               for (int b = 0; b < PAT_PER_REG; b++) begin
                  pattern_ff[{csr_index[1:0], PAT_LO_W'(b)}] <=
                     csr_write_data[mbps_pkg::BYTE_W*b +: mbps_pkg::BYTE_W];
               end
            end
            mbps_pkg::CSR_CARE_MASK: begin
               care_ff <= csr_write_data[mbps_pkg::CARE_W-1:0];
            end
            mbps_pkg::CSR_PATTERN_LENGTH: begin
               length_ff <= csr_write_data[mbps_pkg::LENGTH_W-1:0];
            end
            default: begin
               // drop writes to unused indexes
            end
         endcase
      end
   end

   // buffer state: advance on each transfer, clear at buffer end
   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff   <= '0;
         seen_ff     <= '0;
         reported_ff <= 1'b0;
      end else if (accept) begin
         if (req_last_byte) begin
            window_ff   <= '0;
            seen_ff     <= '0;
            reported_ff <= 1'b0;
         end else begin
            window_ff   <= window_in;
            seen_ff     <= seen_in;
            reported_ff <= reported_ff || found;
         end
      end
   end

endmodule

FILE: sv/mbps_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbps_queue - short result queue between intake and delivery
// Small circular buffer in flops that lets each side stall on its own.
// ----------------------------------------------------------------------------
module mbps_queue (
   input  logic                       clock,
   input  logic                       reset,
   input  mbps_pkg::result_push_type  push,
   input  logic                       pop,
   output logic                       full,
   output logic                       not_empty,
   output mbps_pkg::result_type       head
);

   localparam logic [mbps_pkg::QUEUE_PTR_W-1:0] LAST_SLOT =
      mbps_pkg::QUEUE_PTR_W'(mbps_pkg::QUEUE_DEPTH - 1);
   localparam logic [mbps_pkg::QUEUE_CNT_W-1:0] DEPTH_COUNT =
      mbps_pkg::QUEUE_CNT_W'(mbps_pkg::QUEUE_DEPTH);

   mbps_pkg::result_type                 slots_ff [mbps_pkg::QUEUE_DEPTH];
   logic [mbps_pkg::QUEUE_PTR_W-1:0]     wr_ptr_ff;
   logic [mbps_pkg::QUEUE_PTR_W-1:0]     rd_ptr_ff;
   logic [mbps_pkg::QUEUE_CNT_W-1:0]     count_ff;
   logic                                 do_push;
   logic                                 do_pop;

   assign full      = (count_ff == DEPTH_COUNT);
   assign not_empty = (count_ff != '0);
   assign head      = slots_ff[rd_ptr_ff];
   assign do_push   = push.valid && !full;
   assign do_pop    = pop && not_empty;

   // store the pushed result
   always_ff @(posedge clock) begin
      if (do_push) begin
         slots_ff[wr_ptr_ff] <= push.result;
      end
   end

   // advance pointers and occupancy
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == LAST_SLOT) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == LAST_SLOT) ? '0 : rd_ptr_ff + 1'b1;
         end
         // hold the count when both or neither side moves
         if (do_push && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

FILE: sv/mbps_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbps_back - result delivery stage
// Pulls results from the queue into the output register and hands them out.
// ----------------------------------------------------------------------------
module mbps_back (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            queue_not_empty,
   input  mbps_pkg::result_type            queue_head,
   output logic                            queue_pop,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [1:0]                      rsp_search_status,
   output logic [mbps_pkg::OFFSET_W-1:0]   rsp_match_offset
);

   logic                  out_valid_ff;
   mbps_pkg::result_type  out_data_ff;
   logic                  slot_free;

   // load when the output register is empty or its transfer completes
   assign slot_free = !out_valid_ff || !rsp_stall;
   assign queue_pop = slot_free && queue_not_empty;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (slot_free) begin
         out_valid_ff <= queue_not_empty;
      end
   end

   always_ff @(posedge clock) begin
      if (queue_pop) begin
         out_data_ff <= queue_head;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_search_status = out_data_ff.status;
   assign rsp_match_offset  = out_data_ff.offset;

endmodule

FILE: sv/masked_byte_pattern_search.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// masked_byte_pattern_search - streaming wildcard byte pattern search
// Top level: intake and compare, a result queue and the output register.
// ----------------------------------------------------------------------------
// The block takes one buffer byte per clock cycle while req_stall is low, and
// gives at most one result per buffer: found with the start offset at the
// first match, else not found (or invalid parameter for a zero or oversized
// pattern length) on the byte flagged last. Each byte is compared in the
// cycle it transfers, against the full masked window in parallel. A result
// is written into a two-entry queue and then into the output register
// before it reaches the rsp port, and req_stall rises only while that queue
// is full because results are held back on the rsp side. Write the
// registers only while no buffer is in flight.
// ----------------------------------------------------------------------------
module masked_byte_pattern_search #(
   parameter int PATTERN_MAX = 32
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [mbps_pkg::BYTE_W-1:0]        req_data_byte,
   input  logic                               req_last_byte,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [1:0]                         rsp_search_status,
   output logic [mbps_pkg::OFFSET_W-1:0]      rsp_match_offset,
   input  logic                               csr_write_enable,
   input  logic [mbps_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [mbps_pkg::CSR_DATA_W-1:0]    csr_write_data
);

   mbps_pkg::result_push_type  push;
   mbps_pkg::result_type       queue_head;
   logic                       queue_full;
   logic                       queue_not_empty;
   logic                       queue_pop;

   mbps_front #(
      .PATTERN_MAX (PATTERN_MAX)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data_byte    (req_data_byte),
      .req_last_byte    (req_last_byte),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .queue_full       (queue_full),
      .push             (push)
   );

   mbps_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .pop       (queue_pop),
      .full      (queue_full),
      .not_empty (queue_not_empty),
      .head      (queue_head)
   );

   mbps_back u_back (
      .clock             (clock),
      .reset             (reset),
      .queue_not_empty   (queue_not_empty),
      .queue_head        (queue_head),
      .queue_pop         (queue_pop),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_search_status (rsp_search_status),
      .rsp_match_offset  (rsp_match_offset)
   );

endmodule
